// ----- sv/tmwf_pkg.sv -----
// Shared constants, types and link structures for the trimmed-mean window filter.
`default_nettype none

package tmwf_pkg;

    localparam int WINDOW      = 7;
    localparam int SAMPLE_BITS = 16;

    // The window is always odd.
    localparam int NWIN = WINDOW | 1;

    localparam int LO_RAW  = (NWIN * 15) / 100;
    localparam int LO_RANK = (LO_RAW > 1) ? LO_RAW : 1;
    localparam int HI_RAW  = ((NWIN * 85) / 100) + 1;
    localparam int HI_RANK = (HI_RAW < (NWIN - 1)) ? HI_RAW : (NWIN - 1);
    localparam int KEEP    = HI_RANK - LO_RANK;

    localparam int AGE_W    = $clog2(NWIN);
    localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_W    = SAMPLE_BITS + $clog2(KEEP) + 1;
    localparam int ABS_W    = SUM_W;
    localparam int MULT_W   = ABS_W + 1;
    localparam int PROD_W   = ABS_W + MULT_W;
    localparam int DIV_SHIFT = ABS_W + $clog2(KEEP);

    localparam logic [AGE_W-1:0] AGE_LAST = AGE_W'(NWIN - 1);

    // Rounded-up reciprocal of the kept count; exact for every magnitude below 2**ABS_W.
    localparam logic [DIV_SHIFT:0] DIV_POW = (DIV_SHIFT + 1)'(1) << DIV_SHIFT;
    localparam logic [MULT_W-1:0]  DIV_MULT =
        MULT_W'((DIV_POW + (DIV_SHIFT + 1)'(KEEP - 1)) / (DIV_SHIFT + 1)'(KEEP));

    // Passed from a cell to its right-hand neighbor.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] val;
        logic [AGE_W-1:0]              age;
        logic                          thru;  // the expiring entry sits at or left of this cell
        logic                          le;    // this cell keeps a value not above the new sample
    } tmwf_fwd_t;

    // Passed from a cell to its left-hand neighbor.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] val;
        logic [AGE_W-1:0]              age;
        logic                          gt;    // stored value is above the new sample
    } tmwf_bwd_t;

    typedef struct packed {
        logic abs_en;
        logic mul_en;
    } tmwf_div_ctl_t;

endpackage

`default_nettype wire

// ----- sv/trimmed_mean_window_filter.sv -----
// Top level of the sliding-window trimmed-mean filter.
//
// Usage: each sample transferred on the s_ channel replaces the oldest entry of a
// window of NWIN samples, and one result, the mean of the window's middle ranks
// (the lowest LO_RANK ranks and all ranks from HI_RANK up are dropped), truncated
// toward zero, leaves on the m_ channel for every sample.
// The window is a chain of cells kept in ascending order; each cell talks only to
// its two neighbors, and the whole chain takes a new sample in the cycle of the
// transfer. The kept ranks are then summed, and the sum is divided by the kept
// count through a reciprocal multiplier.
// The chain update, the sum, the magnitude, the multiply and the output register
// are registered in that order, and one sample is in flight at a time: a new
// sample is taken only once the finished quotient of the last one has moved on
// to the output register.
// Reset (aresetn low at a clock edge) fills the window with zeros, empties the
// pipeline and drops any waiting result.
// When the receiver stalls, the result holds in the output register, the finished
// quotient waits in the last stage, and s_tready stays low until it moves on.
`default_nettype none

module trimmed_mean_window_filter
    import tmwf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [15:0] sample
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata    // [15:0] smoothed
);

    tmwf_fwd_t fwd [NWIN+1];
    tmwf_bwd_t bwd [NWIN+1];

    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          in_xfer;

    logic rank_vld_reg, rank_vld_next;
    logic sum_vld_reg,  sum_vld_next;
    logic abs_vld_reg,  abs_vld_next;
    logic mul_vld_reg,  mul_vld_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;
    logic out_load;

    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] quot;
    logic [TDATA_W-1:0]            m_tdata_reg;
    tmwf_div_ctl_t                 div_ctl;
    logic                          sorted_ok;

    assign sample   = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign s_tready = !(rank_vld_reg | sum_vld_reg | abs_vld_reg | mul_vld_reg);
    assign in_xfer  = s_tvalid & s_tready;

    // Chain ends: the left end counts as holding only values not above the sample,
    // so the first cell becomes the insert point whenever its new value would lie
    // above it. The right end always compares above any sample so the last cell
    // never keeps its place below it.
    assign fwd[0]    = '{val: '0, age: '0, thru: 1'b0, le: 1'b1};
    assign bwd[NWIN] = '{val: '0, age: '0, gt: 1'b1};

    // Ages start unique; the entries are all zero, so their order does not matter.
    for (genvar i = 0; i < NWIN; i++) begin : g_cell
        tmwf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (in_xfer),
            .sample     (sample),
            .init_age   (AGE_W'(i)),
            .from_left  (fwd[i]),
            .from_right (bwd[i+1]),
            .to_right   (fwd[i+1]),
            .to_left    (bwd[i])
        );
    end

    // Sum of the kept ranks; cell r holds rank r.
    always_comb begin
        sum_next = '0;
        for (int r = LO_RANK; r < HI_RANK; r++) begin
            sum_next = sum_next + SUM_W'(fwd[r+1].val);
        end
    end

    assign div_ctl = '{abs_en: sum_vld_reg, mul_en: abs_vld_reg};

    tmwf_div u_div (
        .aclk   (aclk),
        .ctl    (div_ctl),
        .sum_in (sum_reg),
        .quot   (quot)
    );

    // The quotient moves to the output register once any earlier result is gone.
    assign out_free      = !m_tvalid_reg || m_tready;
    assign out_load      = mul_vld_reg && out_free;
    assign rank_vld_next = in_xfer;
    assign sum_vld_next  = rank_vld_reg;
    assign abs_vld_next  = sum_vld_reg;
    assign mul_vld_next  = abs_vld_reg || (mul_vld_reg && !out_free);
    assign m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            abs_vld_reg  <= 1'b0;
            mul_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rank_vld_reg <= rank_vld_next;
            sum_vld_reg  <= sum_vld_next;
            abs_vld_reg  <= abs_vld_next;
            mul_vld_reg  <= mul_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rank_vld_reg) begin
            sum_reg <= sum_next;
        end
        if (out_load) begin
            m_tdata_reg <= TDATA_W'(unsigned'(quot));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The chain must stay in ascending order after every update.
    always_comb begin
        sorted_ok = 1'b1;
        for (int i = 0; i < NWIN - 1; i++) begin
            if (fwd[i+1].val > fwd[i+2].val) begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_chain_sorted : assert property (@(posedge aclk) disable iff (!aresetn)
        sorted_ok)
        else $error("window chain out of order");

    a_one_in_flight : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({rank_vld_reg, sum_vld_reg, abs_vld_reg, mul_vld_reg}))
        else $error("more than one sample in the pipeline");

    a_accept_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> rank_vld_reg)
        else $error("accepted sample did not enter the pipeline");

    a_last_stage_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_vld_reg && m_tvalid && !m_tready) |=> (mul_vld_reg && m_tvalid))
        else $error("finished quotient lost while the output was stalled");

endmodule

`default_nettype wire

// ----- sv/tmwf_cell.sv -----
// One cell of the sorted window chain: holds a sample and its age.
`default_nettype none

module tmwf_cell
    import tmwf_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic [AGE_W-1:0]              init_age,
    input  wire tmwf_fwd_t                     from_left,
    input  wire tmwf_bwd_t                     from_right,
    output tmwf_fwd_t                          to_right,
    output tmwf_bwd_t                          to_left
);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [AGE_W-1:0]              age_reg, age_next;
    logic                          thru;
    logic                          le;
    logic                          gt_own;

    assign gt_own = val_reg > sample;
    assign thru   = from_left.thru | (age_reg == AGE_LAST);
    assign le     = thru ? !from_right.gt : !gt_own;

    assign to_right = '{val: val_reg, age: age_reg, thru: thru, le: le};
    assign to_left  = '{val: val_reg, age: age_reg, gt: gt_own};

    // With the oldest entry removed, the list below the insert point stays or moves
    // left, the new sample lands at the insert point, and the rest moves right.
    // The insert point is the first cell whose new value would lie above the sample.
    always_comb begin
        if (le) begin
            if (thru) begin
                val_next = from_right.val;
                age_next = from_right.age + 1'b1;
            end else begin
                val_next = val_reg;
                age_next = age_reg + 1'b1;
            end
        end else if (from_left.le) begin
            val_next = sample;
            age_next = '0;
        end else if (from_left.thru) begin
            val_next = val_reg;
            age_next = age_reg + 1'b1;
        end else begin
            val_next = from_left.val;
            age_next = from_left.age + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
            age_reg <= init_age;
        end else if (load) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tmwf_div.sv -----
// Signed division of the kept-rank sum by the constant kept count, truncated toward zero.
`default_nettype none

module tmwf_div
    import tmwf_pkg::*;
(
    input  wire logic                          aclk,
    input  wire tmwf_div_ctl_t                 ctl,
    input  wire logic signed [SUM_W-1:0]       sum_in,
    output logic signed [SAMPLE_BITS-1:0]      quot
);

    logic [ABS_W-1:0]       abs_reg, abs_next;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0] q_mag;

    assign abs_next  = sum_in[SUM_W-1] ? (ABS_W'(~sum_in) + ABS_W'(1)) : ABS_W'(sum_in);
    assign prod_next = PROD_W'(abs_reg) * PROD_W'(DIV_MULT);
    assign q_mag     = prod_reg[DIV_SHIFT +: SAMPLE_BITS];
    assign quot      = neg_reg ? $signed(~q_mag + 1'b1) : $signed(q_mag);

    always_ff @(posedge aclk) begin
        if (ctl.abs_en) begin
            abs_reg <= abs_next;
            neg_reg <= sum_in[SUM_W-1];
        end
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire
